// ===== src/dwc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types and constants of the depthwise convolution core.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DATA_BITS  = 16;
  localparam int FRAC_BITS  = 13;
  localparam int TAP_COUNT  = 25;
  localparam int SAT_BITS   = (DATA_BITS > 16) ? 16 : DATA_BITS;

  localparam int POS_W   = 6;                          // row and column fields
  localparam int DIM_W   = 7;                          // plane size registers
  localparam int COORD_W = 9;                          // signed window coordinate
  localparam int TAP_W   = 5;
  localparam int KCNT_W  = 3;                          // window row and column counters
  localparam int PIX_AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PROD_W  = 2 * DATA_BITS;
  localparam int ACC_W   = 2 * DATA_BITS + TAP_W;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [1:0] {
    CMD_TAP     = 2'd0,
    CMD_BIAS    = 2'd1,
    CMD_PIXEL   = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KMODE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/dwc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_in_if
// Command channel of the depthwise convolution core.
// ----------------------------------------------------------------------------
interface dwc_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [dwc_pkg::POS_W-1:0]           row;
  logic [dwc_pkg::POS_W-1:0]           col;
  logic [dwc_pkg::TAP_W-1:0]           tap_index;
  logic signed [dwc_pkg::DATA_BITS-1:0] value;

  modport source (output valid, command, row, col, tap_index, value, input ready);
  modport sink   (input valid, command, row, col, tap_index, value, output ready);
endinterface
`default_nettype wire

// ===== src/dwc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_out_if
// Result channel of the depthwise convolution core.
// ----------------------------------------------------------------------------
interface dwc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dwc_pkg::SAT_BITS-1:0]  result;
  logic                                 out_of_range;

  modport source (output valid, result, out_of_range, input ready);
  modport sink   (input valid, result, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== src/depthwise_conv_same_pad_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depthwise_conv_same_pad_core
// Depthwise 3x3 / 5x5 convolution of one plane with zero padding.
// ----------------------------------------------------------------------------
// Usage: the host writes plane size and kernel mode over the APB port, then
// sends commands on in_ch: tap writes, a bias write, pixel writes (stored at
// row*64+col) and compute requests. Every write command is one transfer and
// completes in the cycle it is taken. A compute transfer yields one result on
// out_ch: the saturated window sum, or zero with out_of_range set when the
// position lies outside the plane.
// Sequencing: after a compute transfer the sequencer reads one pixel and one
// tap per cycle for the 9 (3x3) or 25 (5x5) taps, drains the read, multiply
// and accumulate pipeline and hands the result over in its done state; only
// then does it take the next command, so a compute is finished before the
// next one is taken. An out-of-range compute goes straight to the done
// state. The single multiply-accumulate unit and the one read port of the
// pixel memory set this. One finished result may wait in the output
// register while the command channel takes new transfers. If the receiver
// stalls, the next compute holds in its done state until the output register
// frees. Reset clears taps, bias and registers (64x64, 3x3); pixel memory is
// undefined until written.
// ----------------------------------------------------------------------------
module depthwise_conv_same_pad_core (
  input  wire                               clk,
  input  wire                               rst_n,
  dwc_in_if.sink                            in_ch,
  dwc_out_if.source                         out_ch,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [dwc_pkg::CFG_AW-1:0]        paddr,
  input  wire  [dwc_pkg::CFG_DW-1:0]        pwdata,
  output logic [dwc_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int DW = dwc_pkg::DATA_BITS;
  localparam logic signed [dwc_pkg::ACC_W-1:0] SAT_HI =
    dwc_pkg::ACC_W'((2 ** (dwc_pkg::SAT_BITS - 1)) - 1);
  localparam logic signed [dwc_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  // Configuration registers
  logic [dwc_pkg::DIM_W-1:0] width_r, height_r;
  logic                      kmode_r;
  logic                      cfg_wr;
  dwc_pkg::reg_idx_t         cfg_idx;

  // Stores
  logic signed [DW-1:0] pix_mem [dwc_pkg::MAX_WIDTH * dwc_pkg::MAX_HEIGHT];
  logic signed [DW-1:0] tap_mem [dwc_pkg::TAP_COUNT];
  logic [dwc_pkg::TAP_COUNT-1:0] tap_vld_r;
  logic signed [DW-1:0] bias_r;

  // Sequencer
  dwc_pkg::state_t state_r, state_nxt;
  dwc_pkg::cmd_t   in_cmd;
  logic            in_fire, cmp_start, cmp_oor;
  logic            issue, last_issue, pipe_empty, out_load;
  logic [dwc_pkg::POS_W-1:0]  row_r, col_r;
  logic [dwc_pkg::KCNT_W-1:0] ky_r, kx_r;
  logic [dwc_pkg::TAP_W-1:0]  tcnt_r;
  logic                       oor_r;

  // Plane bounds and window geometry
  logic [dwc_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic [dwc_pkg::KCNT_W-1:0] ksize;
  logic [dwc_pkg::TAP_W-1:0]  ktaps;
  logic signed [dwc_pkg::COORD_W-1:0] kpad, win_y, win_x;
  logic                       win_in;
  logic [dwc_pkg::PIX_AW-1:0] rd_addr, wr_addr;

  // Datapath pipeline
  logic                  s1_v_r, s1_use_r, s1_tv_r;
  logic signed [DW-1:0]  pix_rd_r, tap_rd_r;
  logic signed [DW-1:0]  tap_eff;
  logic                  s2_v_r;
  logic signed [dwc_pkg::PROD_W-1:0] prod_r;
  logic signed [dwc_pkg::ACC_W-1:0]  acc_r, shifted;
  logic signed [dwc_pkg::SAT_BITS-1:0] sat_val;

  // Output register
  logic                                out_valid_r, out_oor_r;
  logic signed [dwc_pkg::SAT_BITS-1:0] out_result_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = dwc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH);
      height_r <= dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT);
      kmode_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dwc_pkg::REG_WIDTH:  width_r  <= pwdata[dwc_pkg::DIM_W-1:0];
        dwc_pkg::REG_HEIGHT: height_r <= pwdata[dwc_pkg::DIM_W-1:0];
        dwc_pkg::REG_KMODE:  kmode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dwc_pkg::REG_WIDTH:  prdata = dwc_pkg::CFG_DW'(width_r);
      dwc_pkg::REG_HEIGHT: prdata = dwc_pkg::CFG_DW'(height_r);
      dwc_pkg::REG_KMODE:  prdata = dwc_pkg::CFG_DW'(kmode_r);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  assign in_cmd  = dwc_pkg::cmd_t'(in_ch.command);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign w_eff = (width_r  > dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH))
                 ? dwc_pkg::DIM_W'(dwc_pkg::MAX_WIDTH)  : width_r;
  assign h_eff = (height_r > dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT))
                 ? dwc_pkg::DIM_W'(dwc_pkg::MAX_HEIGHT) : height_r;
  assign ksize = kmode_r ? dwc_pkg::KCNT_W'(5) : dwc_pkg::KCNT_W'(3);
  assign ktaps = kmode_r ? dwc_pkg::TAP_W'(25) : dwc_pkg::TAP_W'(9);
  assign kpad  = kmode_r ? dwc_pkg::COORD_W'(2) : dwc_pkg::COORD_W'(1);

  assign cmp_start = in_fire && (in_cmd == dwc_pkg::CMD_COMPUTE);
  assign cmp_oor   = ({1'b0, in_ch.row} >= h_eff) || ({1'b0, in_ch.col} >= w_eff);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign last_issue = (tcnt_r == ktaps - dwc_pkg::TAP_W'(1));
  assign pipe_empty = !s1_v_r && !s2_v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwc_pkg::ST_IDLE:  if (cmp_start) state_nxt = cmp_oor ? dwc_pkg::ST_DONE : dwc_pkg::ST_RUN;
      dwc_pkg::ST_RUN:   if (last_issue) state_nxt = dwc_pkg::ST_DRAIN;
      dwc_pkg::ST_DRAIN: if (pipe_empty) state_nxt = dwc_pkg::ST_DONE;
      dwc_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = dwc_pkg::ST_IDLE;
      default:           state_nxt = dwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      dwc_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      dwc_pkg::ST_RUN:   issue       = 1'b1;
      dwc_pkg::ST_DRAIN: ;
      dwc_pkg::ST_DONE:  out_load    = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwc_pkg::ST_IDLE;
      ky_r    <= '0;
      kx_r    <= '0;
      tcnt_r  <= '0;
      oor_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmp_start) begin
        ky_r   <= '0;
        kx_r   <= '0;
        tcnt_r <= '0;
        oor_r  <= cmp_oor;
      end else if (issue) begin
        tcnt_r <= tcnt_r + dwc_pkg::TAP_W'(1);
        if (kx_r == ksize - dwc_pkg::KCNT_W'(1)) begin
          kx_r <= '0;
          ky_r <= ky_r + dwc_pkg::KCNT_W'(1);
        end else begin
          kx_r <= kx_r + dwc_pkg::KCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_start) begin
      row_r <= in_ch.row;
      col_r <= in_ch.col;
    end
  end

  // --------------------------------------------------------------------------
  // Window position of the current tap
  // --------------------------------------------------------------------------
  assign win_y  = dwc_pkg::COORD_W'(row_r) + dwc_pkg::COORD_W'(ky_r) - kpad;
  assign win_x  = dwc_pkg::COORD_W'(col_r) + dwc_pkg::COORD_W'(kx_r) - kpad;
  assign win_in = (win_y >= 0) && (win_y < $signed(dwc_pkg::COORD_W'(h_eff))) &&
                  (win_x >= 0) && (win_x < $signed(dwc_pkg::COORD_W'(w_eff)));
  assign rd_addr = win_in
    ? dwc_pkg::PIX_AW'(win_y[dwc_pkg::POS_W-1:0]) * dwc_pkg::PIX_AW'(dwc_pkg::MAX_WIDTH)
      + dwc_pkg::PIX_AW'(win_x[dwc_pkg::POS_W-1:0])
    : '0;
  assign wr_addr = dwc_pkg::PIX_AW'(in_ch.row) * dwc_pkg::PIX_AW'(dwc_pkg::MAX_WIDTH)
                   + dwc_pkg::PIX_AW'(in_ch.col);

  // --------------------------------------------------------------------------
  // Stores: pixel memory, tap memory with per-entry valid bits, bias
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == dwc_pkg::CMD_PIXEL)) begin
      pix_mem[wr_addr] <= in_ch.value;
    end
    pix_rd_r <= pix_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == dwc_pkg::CMD_TAP) &&
        (in_ch.tap_index < dwc_pkg::TAP_W'(dwc_pkg::TAP_COUNT))) begin
      tap_mem[in_ch.tap_index] <= in_ch.value;
    end
    tap_rd_r <= tap_mem[tcnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r <= '0;
      bias_r    <= '0;
    end else if (in_fire) begin
      if ((in_cmd == dwc_pkg::CMD_TAP) &&
          (in_ch.tap_index < dwc_pkg::TAP_W'(dwc_pkg::TAP_COUNT))) begin
        tap_vld_r[in_ch.tap_index] <= 1'b1;
      end
      if (in_cmd == dwc_pkg::CMD_BIAS) begin
        bias_r <= in_ch.value;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate pipeline
  // --------------------------------------------------------------------------
  // A tap that has never been written reads as zero.
  assign tap_eff = s1_tv_r ? tap_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_use_r <= win_in;
    s1_tv_r  <= tap_vld_r[tcnt_r];
    prod_r   <= s1_use_r ? pix_rd_r * tap_eff : dwc_pkg::PROD_W'(0);
    if (cmp_start) begin
      acc_r <= dwc_pkg::ACC_W'(bias_r) <<< dwc_pkg::FRAC_BITS;
    end else if (s2_v_r) begin
      acc_r <= acc_r + dwc_pkg::ACC_W'(prod_r);
    end
  end

  // Arithmetic shift rounds towards minus infinity, then clamp to the sample range.
  assign shifted = acc_r >>> dwc_pkg::FRAC_BITS;
  always_comb begin
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[dwc_pkg::SAT_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[dwc_pkg::SAT_BITS-1:0];
    end else begin
      sat_val = shifted[dwc_pkg::SAT_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_r <= oor_r ? '0 : sat_val;
      out_oor_r    <= oor_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result       = out_result_r;
  assign out_ch.out_of_range = out_oor_r;

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_result_r == '0))
    else $error("out-of-range result carries a non-zero value");

  a_compute_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_start |=> (state_r != dwc_pkg::ST_IDLE))
    else $error("compute transfer did not start the sequencer");

  a_tap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwc_pkg::ST_RUN) |-> (tcnt_r < ktaps))
    else $error("tap counter ran past the kernel");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwc_pkg::ST_DONE) |-> (!s1_v_r && !s2_v_r))
    else $error("result taken before the accumulator settled");
`endif

endmodule
`default_nettype wire

// ===== tb/depthwise_conv_same_pad_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depthwise_conv_same_pad_core_tb
// Self-checking bench for the depthwise 3x3 / 5x5 convolution core.
// Filter taps, bias and pixels are loaded over the command channel, and
// compute requests are checked against a behavioural window-sum predictor.
// The predictor covers zero padding at the plane borders, floor shifting and
// saturation. Plane size and kernel mode are changed over APB between phases.
// Pixels are loaded before any window reads them. The sender works in random
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module depthwise_conv_same_pad_core_tb;

  typedef struct packed {
    logic signed [dwc_pkg::SAT_BITS-1:0] result;
    logic                                out_of_range;
  } conv_result_t;

  // Holds a copy of the core's stores and registers, and the queue of window
  // sums still owed by the core.
  class window_sum_checker;
    logic signed [dwc_pkg::DATA_BITS-1:0] pixels [dwc_pkg::MAX_WIDTH*dwc_pkg::MAX_HEIGHT];
    logic signed [dwc_pkg::DATA_BITS-1:0] taps [dwc_pkg::TAP_COUNT];
    logic signed [dwc_pkg::DATA_BITS-1:0] bias;
    int unsigned                 width_reg;
    int unsigned                 height_reg;
    bit                          five_by_five;
    conv_result_t                pending[$];
    int                          errors;
    int                          commands_seen;
    int                          sums_seen;
    int                          saturated_seen;
    int                          outside_seen;

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (pixels[i]) pixels[i] = '0;
      bias         = '0;
      width_reg    = 64;
      height_reg   = 64;
      five_by_five = 1'b0;
    endfunction

    function void write_register(dwc_pkg::reg_idx_t idx, logic [dwc_pkg::CFG_DW-1:0] data);
      case (idx)
        dwc_pkg::REG_WIDTH:  width_reg = 32'(data[dwc_pkg::DIM_W-1:0]);
        dwc_pkg::REG_HEIGHT: height_reg = 32'(data[dwc_pkg::DIM_W-1:0]);
        dwc_pkg::REG_KMODE:  five_by_five = data[0];
        default: ;
      endcase
    endfunction

    function conv_result_t window_sum(int row, int col);
      conv_result_t r;
      longint       acc;
      longint       hi;
      longint       lo;
      int           w;
      int           h;
      int           span;
      int           pad;
      int           y;
      int           x;
      w    = (width_reg > dwc_pkg::MAX_WIDTH) ? dwc_pkg::MAX_WIDTH : width_reg;
      h    = (height_reg > dwc_pkg::MAX_HEIGHT) ? dwc_pkg::MAX_HEIGHT : height_reg;
      span = five_by_five ? 5 : 3;
      pad  = five_by_five ? 2 : 1;
      if (row >= h || col >= w) begin
        r.result       = '0;
        r.out_of_range = 1'b1;
        return r;
      end
      acc = longint'(bias) * (longint'(1) << dwc_pkg::FRAC_BITS);
      for (int ky = 0; ky < span; ky++) begin
        for (int kx = 0; kx < span; kx++) begin
          y = row + ky - pad;
          x = col + kx - pad;
          if (y >= 0 && y < h && x >= 0 && x < w)
            acc += longint'(pixels[y*dwc_pkg::MAX_WIDTH + x]) *
                   longint'(taps[ky*span + kx]);
        end
      end
      // Arithmetic shift of a signed value rounds towards minus infinity.
      acc = acc >>> dwc_pkg::FRAC_BITS;
      hi  = (longint'(1) << (dwc_pkg::SAT_BITS - 1)) - 1;
      lo  = -hi - 1;
      if (acc > hi) acc = hi;
      else if (acc < lo) acc = lo;
      r.result       = acc[dwc_pkg::SAT_BITS-1:0];
      r.out_of_range = 1'b0;
      return r;
    endfunction

    function void note_command(dwc_pkg::cmd_t cmd, int row, int col, int tap,
                               logic signed [dwc_pkg::DATA_BITS-1:0] value);
      commands_seen++;
      case (cmd)
        dwc_pkg::CMD_TAP:     if (tap < dwc_pkg::TAP_COUNT) taps[tap] = value;
        dwc_pkg::CMD_BIAS:    bias = value;
        dwc_pkg::CMD_PIXEL:
          if (row < dwc_pkg::MAX_HEIGHT && col < dwc_pkg::MAX_WIDTH)
            pixels[row*dwc_pkg::MAX_WIDTH + col] = value;
        dwc_pkg::CMD_COMPUTE: pending.push_back(window_sum(row, col));
        default: ;
      endcase
    endfunction

    function void check_output(logic signed [dwc_pkg::SAT_BITS-1:0] result,
                               logic out_of_range);
      conv_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: result %0d out_of_range %0b",
               result, out_of_range);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0b, got %0b", want.out_of_range, out_of_range);
        errors++;
      end
      if (result !== want.result) begin
        $error("result: expected %0d, got %0d", $signed(want.result), result);
        errors++;
      end
      if (want.out_of_range) outside_seen++;
      else begin
        sums_seen++;
        if (want.result == {1'b0, {(dwc_pkg::SAT_BITS-1){1'b1}}} ||
            want.result == {1'b1, {(dwc_pkg::SAT_BITS-1){1'b0}}})
          saturated_seen++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_WAIT = 40;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dwc_pkg::CFG_AW-1:0]   paddr;
  logic [dwc_pkg::CFG_DW-1:0]   pwdata;
  logic [dwc_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;

  dwc_in_if  in_bus ();
  dwc_out_if out_bus ();

  window_sum_checker sb = new();

  // Stimulus-side view of the plane, used to load pixels before they are read.
  bit pixel_loaded [dwc_pkg::MAX_WIDTH*dwc_pkg::MAX_HEIGHT];
  int plane_w = 64;
  int plane_h = 64;
  bit plane_k = 1'b0;
  int burst_left = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  depthwise_conv_same_pad_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_command(dwc_pkg::cmd_t'(in_bus.command), int'(in_bus.row), int'(in_bus.col),
                      int'(in_bus.tap_index), in_bus.value);
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_output(out_bus.result, out_bus.out_of_range);
  end

  // Receiver: switches between always ready, random stalls and long stalls.
  initial begin
    int ready_mode;
    int mode_left;
    ready_mode = 0;
    mode_left  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= 1'($urandom_range(0, 1));
        default: out_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.pending.size());
      $display("depthwise_conv_same_pad_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [dwc_pkg::DATA_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return dwc_pkg::DATA_BITS'($urandom_range(0, 511) - 256);
      default: return dwc_pkg::DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0:          return 0;
      1, 2:       return $urandom_range(65, 127);
      3, 4, 5:    return 64;
      6, 7:       return $urandom_range(13, 63);
      default:    return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int eff_w();
    return (plane_w > dwc_pkg::MAX_WIDTH) ? dwc_pkg::MAX_WIDTH : plane_w;
  endfunction

  function automatic int eff_h();
    return (plane_h > dwc_pkg::MAX_HEIGHT) ? dwc_pkg::MAX_HEIGHT : plane_h;
  endfunction

  // Presents one command and holds it until the core takes the transfer.
  task automatic send_command(dwc_pkg::cmd_t cmd, int row, int col, int tap,
                              logic signed [dwc_pkg::DATA_BITS-1:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.row       <= row[dwc_pkg::POS_W-1:0];
    in_bus.col       <= col[dwc_pkg::POS_W-1:0];
    in_bus.tap_index <= tap[dwc_pkg::TAP_W-1:0];
    in_bus.value     <= value;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_until_drained();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_register(dwc_pkg::reg_idx_t idx, logic [dwc_pkg::CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, bit k);
    wait_until_drained();
    write_register(dwc_pkg::REG_WIDTH, w);
    write_register(dwc_pkg::REG_HEIGHT, h);
    write_register(dwc_pkg::REG_KMODE, dwc_pkg::CFG_DW'(k));
    plane_w = w;
    plane_h = h;
    plane_k = k;
    settings_used++;
  endtask

  task automatic write_pixel(int row, int col, logic signed [dwc_pkg::DATA_BITS-1:0] value);
    send_command(dwc_pkg::CMD_PIXEL, row, col, $urandom_range(0, 31), value);
    pixel_loaded[row*dwc_pkg::MAX_WIDTH + col] = 1'b1;
  endtask

  task automatic compute_at(int row, int col);
    int pad;
    int y;
    int x;
    pad = plane_k ? 2 : 1;
    // Every in-plane pixel of the window must hold a written value first.
    if (row < eff_h() && col < eff_w()) begin
      for (int ky = 0; ky <= 2*pad; ky++) begin
        for (int kx = 0; kx <= 2*pad; kx++) begin
          y = row + ky - pad;
          x = col + kx - pad;
          if (y >= 0 && y < eff_h() && x >= 0 && x < eff_w() &&
              !pixel_loaded[y*dwc_pkg::MAX_WIDTH + x])
            write_pixel(y, x, pick_sample());
        end
      end
    end
    send_command(dwc_pkg::CMD_COMPUTE, row, col, $urandom_range(0, 31),
                 dwc_pkg::DATA_BITS'($urandom));
  endtask

  // Sends random commands until about n_items transfers, pixel preloads included.
  task automatic random_phase(int n_items);
    int pick;
    int row;
    int col;
    bit in_plane;
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick     = $urandom_range(0, 99);
      in_plane = (eff_w() > 0 && eff_h() > 0 && $urandom_range(0, 9) < 8);
      row      = in_plane ? $urandom_range(0, eff_h() - 1) : $urandom_range(0, 63);
      col      = in_plane ? $urandom_range(0, eff_w() - 1) : $urandom_range(0, 63);
      if (pick < 10)
        send_command(dwc_pkg::CMD_TAP, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 31), pick_sample());
      else if (pick < 13)
        send_command(dwc_pkg::CMD_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 31), pick_sample());
      else if (pick < 35)
        write_pixel(row, col, pick_sample());
      else
        compute_at(row, col);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.command   <= dwc_pkg::CMD_TAP;
    in_bus.row       <= '0;
    in_bus.col       <= '0;
    in_bus.tap_index <= '0;
    in_bus.value     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first on the reset setting of a 64x64 plane and 3x3 filter.
    send_command(dwc_pkg::CMD_TAP, 0, 0, 0, 16'sh7FFF);
    send_command(dwc_pkg::CMD_TAP, 0, 0, 4, 16'sh8000);
    send_command(dwc_pkg::CMD_TAP, 0, 0, 8, 16'sh2000);
    send_command(dwc_pkg::CMD_TAP, 0, 0, 20, 16'sh1000);   // outside the 3x3 window
    send_command(dwc_pkg::CMD_TAP, 0, 0, 27, 16'sh5555);   // no such tap, dropped
    send_command(dwc_pkg::CMD_BIAS, 0, 0, 0, 16'sh8000);
    write_pixel(0, 0, 16'sh7FFF);
    write_pixel(63, 63, 16'sh8000);
    write_pixel(1, 1, 16'sh7FFF);
    compute_at(0, 0);
    compute_at(63, 63);
    compute_at(0, 63);
    send_command(dwc_pkg::CMD_BIAS, 63, 63, 31, 16'sh7FFF);
    compute_at(1, 1);
    // A small plane with the 5x5 filter, which brings tap 20 into use.
    configure(5, 3, 1'b1);
    compute_at(2, 4);
    compute_at(3, 0);
    compute_at(0, 5);
    compute_at(63, 63);
    // Zero width leaves no position inside the plane.
    configure(0, 64, 1'b0);
    compute_at(0, 0);
    // Sizes beyond the store act as the full store.
    configure(127, 100, 1'b1);
    compute_at(62, 1);
    compute_at(63, 63);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       configure(1, 1, 1'b0);
        1:       configure(64, 64, 1'b1);
        default: configure(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      endcase
      random_phase(60);
    end

    wait_until_drained();
    $display("Checked %0d commands across %0d plane settings: %0d window sums (%0d saturated)",
             sb.commands_seen, settings_used, sb.sums_seen, sb.saturated_seen);
    $display("and %0d requests outside the plane.", sb.outside_seen);
    if (sb.errors == 0)
      $display("depthwise_conv_same_pad_core_tb: clean");
    else
      $display("depthwise_conv_same_pad_core_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
